// ----- rtl/core/xtea_block_cipher_assert.svh -----
// Assertion macros for the XTEA block cipher, sampled on clk_i with rst_ni as reset.
`ifndef XTEA_BLOCK_CIPHER_ASSERT_SVH
`define XTEA_BLOCK_CIPHER_ASSERT_SVH

`ifndef SYNTHESIS
`define XTEA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("xtea assertion failed");
`define XTEA_ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("xtea assertion failed");
`else
`define XTEA_ASSERT(lbl, prop)
`define XTEA_ASSERT_NEVER(lbl, prop)
`endif

`endif

// ----- rtl/core/xtea_pkg.sv -----
// Package with the types, constants and mixing function of the XTEA block cipher.
`timescale 1ns / 1ps

package xtea_pkg;

  localparam int unsigned WordW        = 32;
  localparam int unsigned KeyWords     = 4;
  localparam int unsigned RoundCountDef = 32;
  localparam int unsigned CfgIdxW      = 3;

  localparam logic [WordW-1:0] XTEA_DELTA = 32'h9e37_79b9;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD_ZERO  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD_ONE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD_TWO   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD_THREE = 3'd3;

  typedef logic [KeyWords-1:0][WordW-1:0] key_t;

  typedef struct packed {
    logic             req_type;
    logic [WordW-1:0] block_first_half;
    logic [WordW-1:0] block_second_half;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] out_first_half;
    logic [WordW-1:0] out_second_half;
  } out_item_t;

  // What travels down the pipeline with each item.
  typedef struct packed {
    logic             decrypt;
    logic [WordW-1:0] v0;
    logic [WordW-1:0] v1;
  } stage_data_t;

  function automatic logic [WordW-1:0] mix_word(input logic [WordW-1:0] v);
    mix_word = ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

// ----- rtl/core/xtea_stage.sv -----
// One XTEA half-round with its pipeline register and handshake.
`timescale 1ns / 1ps

module xtea_stage #(
  parameter int unsigned ROUND_COUNT = xtea_pkg::RoundCountDef,
  parameter int unsigned STAGE_IDX   = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  xtea_pkg::key_t        key_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  xtea_pkg::stage_data_t data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output xtea_pkg::stage_data_t data_o
);
  import xtea_pkg::*;

  localparam int unsigned Round  = STAGE_IDX / 2;
  localparam bit          IsEven = (STAGE_IDX % 2) == 0;
  localparam int unsigned EncMul = IsEven ? Round : Round + 1;
  localparam int unsigned DecMul = IsEven ? ROUND_COUNT - Round : ROUND_COUNT - Round - 1;

  localparam logic [WordW-1:0] EncSum = XTEA_DELTA * WordW'(EncMul);
  localparam logic [WordW-1:0] DecSum = XTEA_DELTA * WordW'(DecMul);
  localparam logic [1:0]       EncSel = IsEven ? EncSum[1:0] : EncSum[12:11];
  localparam logic [1:0]       DecSel = IsEven ? DecSum[12:11] : DecSum[1:0];

  logic                  valid_q;
  stage_data_t           data_q;
  stage_data_t           data_d;
  logic                  upd_first;
  logic [WordW-1:0]      src_word;
  logic [WordW-1:0]      dst_word;
  logic [WordW-1:0]      sum_key;
  logic [WordW-1:0]      tweak;
  logic [WordW-1:0]      new_word;

  // Even half-rounds of encryption and odd ones of decryption update v0.
  always_comb begin
    upd_first = IsEven ^ data_i.decrypt;
    src_word  = upd_first ? data_i.v1 : data_i.v0;
    dst_word  = upd_first ? data_i.v0 : data_i.v1;
    sum_key   = data_i.decrypt ? (DecSum + key_i[DecSel]) : (EncSum + key_i[EncSel]);
    tweak     = mix_word(src_word) ^ sum_key;
    new_word  = data_i.decrypt ? (dst_word - tweak) : (dst_word + tweak);
    data_d    = data_i;
    if (upd_first) begin
      data_d.v0 = new_word;
    end else begin
      data_d.v1 = new_word;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/core/xtea_block_cipher.sv -----
// XTEA block cipher: key registers and a pipeline of one half-round per stage.
//
// Usage: load the 128-bit key through the write port (cfg_we_i, cfg_idx_i,
// cfg_wdata_i), index 0 to 3 for key words zero to three; writes to higher
// indexes are ignored. The user must change the key only while no item is in
// flight; the block does not enforce this. Each input item carries a request
// type (0 encrypt, 1 decrypt) and the two 32-bit halves of a block; each
// yields exactly one output item with the transformed halves. Both channels
// use valid and ready. Each stage performs one half-round: one mix, one key
// addition and one add or subtract, and registers its result.
// Throughput is one item per cycle while out_ready_i is high. Each stage
// holds its item while the next one is full, so a stalled receiver fills the
// pipeline from the far end and empty slots keep being filled until every
// stage is occupied; only then is in_ready_o lowered. Nothing is lost or
// repeated. Reset clears all stage valid bits and sets the key words to zero.
`timescale 1ns / 1ps

module xtea_block_cipher #(
  parameter int unsigned ROUND_COUNT = xtea_pkg::RoundCountDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [xtea_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [xtea_pkg::WordW-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  xtea_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output xtea_pkg::out_item_t             out_item_o
);
  import xtea_pkg::*;

  `include "xtea_block_cipher_assert.svh"

  localparam int unsigned StageCnt = 2 * ROUND_COUNT;

  key_t key_q;
  key_t key_d;

  logic        stage_valid [StageCnt+1];
  logic        stage_ready [StageCnt+1];
  stage_data_t stage_data  [StageCnt+1];

  // Key registers: only the four key indexes take a write.
  always_comb begin
    key_d = key_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_WORD_ZERO:  key_d[0] = cfg_wdata_i;
        CFG_KEY_WORD_ONE:   key_d[1] = cfg_wdata_i;
        CFG_KEY_WORD_TWO:   key_d[2] = cfg_wdata_i;
        CFG_KEY_WORD_THREE: key_d[3] = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  // Entry of the pipeline.
  assign stage_valid[0] = in_valid_i;
  assign stage_data[0]  = '{decrypt: in_item_i.req_type,
                            v0:      in_item_i.block_first_half,
                            v1:      in_item_i.block_second_half};
  assign in_ready_o     = stage_ready[0];

  for (genvar s = 0; s < StageCnt; s++) begin : g_stage
    xtea_stage #(
      .ROUND_COUNT (ROUND_COUNT),
      .STAGE_IDX   (s)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key_q),
      .valid_i (stage_valid[s]),
      .ready_o (stage_ready[s]),
      .data_i  (stage_data[s]),
      .valid_o (stage_valid[s+1]),
      .ready_i (stage_ready[s+1]),
      .data_o  (stage_data[s+1])
    );
  end

  // The last stage register is the output register.
  assign stage_ready[StageCnt] = out_ready_i;
  assign out_valid_o           = stage_valid[StageCnt];
  assign out_item_o            = '{out_first_half:  stage_data[StageCnt].v0,
                                   out_second_half: stage_data[StageCnt].v1};

  // An accepted item always lands in the first stage.
  `XTEA_ASSERT(a_accept_lands, in_valid_i && in_ready_o |=> stage_valid[1])
  // The input side only stalls once the first stage holds an item that cannot move.
  `XTEA_ASSERT_NEVER(a_stall_needs_full, !in_ready_o && !stage_valid[1])
  // A write to key word zero reaches its register on the next edge.
  `XTEA_ASSERT(a_key_write,
      cfg_we_i && cfg_idx_i == CFG_KEY_WORD_ZERO |=> key_q[0] == $past(cfg_wdata_i))

endmodule
